### hw/rtl/lepg_pkg.sv
// shared widths, register codes and effect mode codes of the led effect pattern generator
package lepg_pkg;

  localparam int unsigned LED_NUMBER = 4;
  localparam int unsigned LED_IDX_W  = 2;
  localparam int unsigned ANGLE_W    = 12;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned MODE_W     = 3;

  localparam logic [LED_IDX_W-1:0] LED_LAST = LED_IDX_W'(LED_NUMBER - 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF      = 3'd0,
    MODE_SOLID    = 3'd1,
    MODE_SPIN     = 3'd2,
    MODE_STROBE   = 3'd3,
    MODE_PULSE    = 3'd4,
    MODE_WAVE     = 3'd5,
    MODE_ATTITUDE = 3'd6,
    MODE_NONE     = 3'd7
  } effect_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE  = 2'd0,
    REG_RED   = 2'd1,
    REG_GREEN = 2'd2,
    REG_BLUE  = 2'd3
  } cfg_reg_e;

endpackage

### hw/rtl/lepg_if.sv
// valid/ready channel interfaces for tick requests and led color requests
interface lepg_tick_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [lepg_pkg::ANGLE_W-1:0]    roll_angle;
  logic signed [lepg_pkg::ANGLE_W-1:0]    pitch_angle;

  modport source (output valid, output roll_angle, output pitch_angle, input ready);
  modport sink (input valid, input roll_angle, input pitch_angle, output ready);
endinterface

interface lepg_led_if;
  logic                               valid;
  logic                               ready;
  logic [lepg_pkg::LED_IDX_W-1:0]     led_id;
  logic [lepg_pkg::COLOR_W-1:0]       red_out;
  logic [lepg_pkg::COLOR_W-1:0]       green_out;
  logic [lepg_pkg::COLOR_W-1:0]       blue_out;
  logic                               frame_end;

  modport source (output valid, output led_id, output red_out, output green_out,
                  output blue_out, output frame_end, input ready);
  modport sink (input valid, input led_id, input red_out, input green_out,
                input blue_out, input frame_end, output ready);
endinterface

### hw/rtl/led_effect_pattern_generator.sv
// led effect pattern generator top level: step counter, tick register and color pipe
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------------------
//  tick_i   | in  | valid/ready   | roll_angle, pitch_angle (signed q7.4)
//  led_o    | out | valid/ready   | led_id, red_out, green_out, blue_out, frame_end
//  cfg      | in  | cfg_we_i      | cfg_index_i, cfg_data_i (write only)
//
// on an emitting tick the tick register hands one led per cycle, unless led_o stalls, to the
// two-stage color pipe (product register, then divide-by-constant into the output register)
// a tick that emits nothing (off/solid after step 0, mode none) sends no led into the pipe
// the first led passes the tick register and the product register into the output register
// reset clears the configuration registers, the step counter and its residues, and empties the pipe
// a stall on led_o holds the pipe; the next tick is taken while the last led enters stage 1
module led_effect_pattern_generator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lepg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lepg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  lepg_tick_if.sink                           tick_i,
  lepg_led_if.source                          led_o
);

  // how a color component is finished in the second stage
  typedef enum logic [1:0] {
    KIND_DIRECT,
    KIND_DIV400,
    KIND_WAVE,
    KIND_DIV255
  } kind_e;

  typedef struct packed {
    logic [lepg_pkg::LED_IDX_W-1:0] led;
    kind_e                          kind;
    logic [2:0][16:0]               prod;
    logic [2:0][7:0]                aux;
  } stage1_t;

  // configuration registers
  lepg_pkg::effect_mode_e mode_q;
  logic [7:0]             red_q, green_q, blue_q;
  logic                   cfg_clear;

  // step counter and its residues (kept so that no wide division is needed)
  logic [31:0] step_q;
  logic [5:0]  mod40_q;
  logic [6:0]  mod100_q;
  logic [7:0]  mod200_q;
  logic [9:0]  mod800_q;
  logic        mode_emits;
  logic        tick_acc;
  logic        step_inc;

  // tick register
  logic                           item_valid_q;
  logic [lepg_pkg::LED_IDX_W-1:0] item_led_q;
  logic signed [11:0]             roll_q, pitch_q;
  logic [5:0]                     it_mod40_q;
  logic [6:0]                     it_mod100_q;
  logic [7:0]                     it_mod200_q;
  logic [9:0]                     it_mod800_q;

  // color pipe
  logic    s1_valid_q;
  stage1_t s1_q, s1_d;
  logic    s1_ready, s1_load;
  logic    out_valid_q;
  logic    s2_ready, s2_load;
  logic [lepg_pkg::LED_IDX_W-1:0] out_led_q;
  logic [7:0]                     out_red_q, out_green_q, out_blue_q;
  logic                           out_frame_end_q;

  logic [7:0] base [3];

  // per-led terms of the first stage
  logic [1:0]  spin_head, spin_tail;
  logic        strobe_hit;
  logic [8:0]  pulse_s;
  logic [8:0]  wave_tmp;
  logic [7:0]  wave_off, wave_ph;
  logic [5:0]  wave_k;
  logic [11:0] wave_b20 [3];
  logic signed [11:0] att_angle;
  logic        att_pos;
  logic [12:0] att_neg;
  logic [11:0] att_mag;
  logic [14:0] att_x5;
  logic [9:0]  att_mraw;
  logic [7:0]  att_m, att_inv;

  // second stage terms
  logic [12:0] s2_y25 [3];
  logic [25:0] s2_p25 [3];
  logic [33:0] s2_p255 [3];
  logic [8:0]  s2_sum [3];
  logic [7:0]  s2_col [3];

  // ---------------------------------------------------------------- configuration
  always_comb begin
    cfg_clear = 1'b0;
    if (cfg_we_i) begin
      unique case (lepg_pkg::cfg_reg_e'(cfg_index_i))
        lepg_pkg::REG_MODE:  cfg_clear = (mode_q != lepg_pkg::effect_mode_e'(cfg_data_i[2:0]));
        lepg_pkg::REG_RED:   cfg_clear = (red_q != cfg_data_i);
        lepg_pkg::REG_GREEN: cfg_clear = (green_q != cfg_data_i);
        lepg_pkg::REG_BLUE:  cfg_clear = (blue_q != cfg_data_i);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= lepg_pkg::MODE_OFF;
      red_q   <= '0;
      green_q <= '0;
      blue_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (lepg_pkg::cfg_reg_e'(cfg_index_i))
        lepg_pkg::REG_MODE:  mode_q  <= lepg_pkg::effect_mode_e'(cfg_data_i[2:0]);
        lepg_pkg::REG_RED:   red_q   <= cfg_data_i;
        lepg_pkg::REG_GREEN: green_q <= cfg_data_i;
        lepg_pkg::REG_BLUE:  blue_q  <= cfg_data_i;
      endcase
    end
  end

  assign base[0] = red_q;
  assign base[1] = green_q;
  assign base[2] = blue_q;

  // ---------------------------------------------------------------- step counter
  // off and solid emit once, on step zero; mode none never emits
  always_comb begin
    unique case (mode_q)
      lepg_pkg::MODE_OFF, lepg_pkg::MODE_SOLID: mode_emits = (step_q == '0);
      lepg_pkg::MODE_NONE:                      mode_emits = 1'b0;
      default:                                  mode_emits = 1'b1;
    endcase
  end

  assign tick_i.ready = !item_valid_q || ((item_led_q == lepg_pkg::LED_LAST) && s1_ready);
  assign tick_acc     = tick_i.valid && tick_i.ready;
  assign step_inc     = tick_acc && mode_emits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= '0;
      mod40_q  <= '0;
      mod100_q <= '0;
      mod200_q <= '0;
      mod800_q <= '0;
    end else if (cfg_clear || (step_inc && (step_q == '1))) begin
      // the 32-bit wrap also restarts the residues
      step_q   <= '0;
      mod40_q  <= '0;
      mod100_q <= '0;
      mod200_q <= '0;
      mod800_q <= '0;
    end else if (step_inc) begin
      step_q   <= step_q + 32'd1;
      mod40_q  <= (mod40_q == 6'd39) ? 6'd0 : mod40_q + 6'd1;
      mod100_q <= (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
      mod200_q <= (mod200_q == 8'd199) ? 8'd0 : mod200_q + 8'd1;
      mod800_q <= (mod800_q == 10'd799) ? 10'd0 : mod800_q + 10'd1;
    end
  end

  // ---------------------------------------------------------------- tick register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      item_led_q   <= '0;
    end else if (step_inc) begin
      item_valid_q <= 1'b1;
      item_led_q   <= '0;
    end else if (s1_load) begin
      if (item_led_q == lepg_pkg::LED_LAST) begin
        item_valid_q <= 1'b0;
      end
      item_led_q <= item_led_q + 2'd1;
    end
  end

  // snapshot of the angles and of the step before its increment
  always_ff @(posedge clk_i) begin
    if (step_inc) begin
      roll_q      <= tick_i.roll_angle;
      pitch_q     <= tick_i.pitch_angle;
      it_mod40_q  <= mod40_q;
      it_mod100_q <= mod100_q;
      it_mod200_q <= mod200_q;
      it_mod800_q <= mod800_q;
    end
  end

  // ---------------------------------------------------------------- stage 1: products
  // spin: head is (step / 10) mod 4, tail the led before it
  assign spin_head = (it_mod40_q >= 6'd30) ? 2'd3 :
                     (it_mod40_q >= 6'd20) ? 2'd2 :
                     (it_mod40_q >= 6'd10) ? 2'd1 : 2'd0;
  assign spin_tail = spin_head - 2'd1;

  // strobe lights on steps 0, 2, 10 and 12 of every 100 steps
  assign strobe_hit = (it_mod100_q == 7'd0) || (it_mod100_q == 7'd2) ||
                      (it_mod100_q == 7'd10) || (it_mod100_q == 7'd12);

  // pulse: triangle over 800 steps
  assign pulse_s = (it_mod800_q < 10'd400) ? it_mod800_q[8:0] : 9'(10'd799 - it_mod800_q);

  // wave: each led lags by 50 steps; comp*5k/250 is comp*k/50
  assign wave_off = {item_led_q, 1'b0} * 8'd25 + 8'd0;
  assign wave_tmp = {1'b0, it_mod200_q} + 9'd200 - {1'b0, wave_off};
  assign wave_ph  = (wave_tmp >= 9'd200) ? 8'(wave_tmp - 9'd200) : wave_tmp[7:0];
  assign wave_k   = (wave_ph < 8'd50)  ? wave_ph[5:0] :
                    (wave_ph < 8'd100) ? 6'(8'd99 - wave_ph) : 6'd0;

  // comp / 20 as ((comp >> 2) * 52) >> 8
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wave_b20[k] = {6'b0, base[k][7:2]} * 12'd52;
    end
  end

  // attitude: left +roll, right -roll, back +pitch, front -pitch
  assign att_angle = item_led_q[0] ? roll_q : pitch_q;
  assign att_pos   = item_led_q[1];
  assign att_neg   = -{att_angle[11], att_angle};
  always_comb begin
    att_mag = '0;
    if (att_pos) begin
      if (!att_angle[11] && (att_angle != 12'sd0)) begin
        att_mag = att_angle;
      end
    end else if (att_angle[11]) begin
      att_mag = att_neg[11:0];
    end
  end
  assign att_x5   = {3'b0, att_mag} + {1'b0, att_mag, 2'b0};
  assign att_mraw = att_x5[13:4];
  assign att_m    = (att_mraw > 10'd255) ? 8'hFF : att_mraw[7:0];
  assign att_inv  = 8'hFF - att_m;

  always_comb begin
    s1_d      = '0;
    s1_d.led  = item_led_q;
    s1_d.kind = KIND_DIRECT;
    unique case (mode_q)
      lepg_pkg::MODE_OFF: begin
      end
      lepg_pkg::MODE_SOLID: begin
        for (int k = 0; k < 3; k++) s1_d.aux[k] = base[k];
      end
      lepg_pkg::MODE_SPIN: begin
        for (int k = 0; k < 3; k++) begin
          if (item_led_q == spin_head) begin
            s1_d.aux[k] = base[k];
          end else if (item_led_q == spin_tail) begin
            s1_d.aux[k] = {3'b000, base[k][7:3]};
          end
        end
      end
      lepg_pkg::MODE_STROBE: begin
        // front and back go white, right and left take the base color
        if (strobe_hit) begin
          for (int k = 0; k < 3; k++) s1_d.aux[k] = item_led_q[0] ? base[k] : 8'hFF;
        end
      end
      lepg_pkg::MODE_PULSE: begin
        s1_d.kind = KIND_DIV400;
        for (int k = 0; k < 3; k++) s1_d.prod[k] = {9'b0, base[k]} * {8'b0, pulse_s};
      end
      lepg_pkg::MODE_WAVE: begin
        s1_d.kind = KIND_WAVE;
        for (int k = 0; k < 3; k++) begin
          s1_d.prod[k] = {9'b0, base[k]} * {11'b0, wave_k};
          s1_d.aux[k]  = {4'b0, wave_b20[k][11:8]};
        end
      end
      lepg_pkg::MODE_ATTITUDE: begin
        s1_d.kind    = KIND_DIV255;
        s1_d.prod[0] = {9'b0, red_q} * {9'b0, att_m};
        s1_d.prod[1] = {7'b0, att_inv, 2'b0} + {9'b0, att_inv};
        s1_d.prod[2] = {9'b0, blue_q} * {9'b0, att_m};
      end
      lepg_pkg::MODE_NONE: begin
      end
    endcase
  end

  assign s2_ready = !out_valid_q || led_o.ready;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign s1_load  = item_valid_q && s1_ready;
  assign s2_load  = s1_valid_q && s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------- stage 2: divides
  // x / 25 as (x * 5243) >> 17, x / 255 as (x * 65794) >> 24, exact over these ranges
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s2_y25[k]  = (s1_q.kind == KIND_DIV400) ? s1_q.prod[k][16:4] : s1_q.prod[k][13:1];
      s2_p25[k]  = {13'b0, s2_y25[k]} * 26'd5243;
      s2_p255[k] = {18'b0, s1_q.prod[k][15:0]} * 34'd65794;
      s2_sum[k]  = {1'b0, s1_q.aux[k]} + s2_p25[k][25:17];
      case (s1_q.kind)
        KIND_DIV400: s2_col[k] = s2_p25[k][24:17];
        KIND_WAVE:   s2_col[k] = s2_sum[k][8] ? 8'hFF : s2_sum[k][7:0];
        KIND_DIV255: s2_col[k] = s2_p255[k][31:24];
        default:     s2_col[k] = s1_q.aux[k];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      out_led_q       <= s1_q.led;
      out_red_q       <= s2_col[0];
      out_green_q     <= s2_col[1];
      out_blue_q      <= s2_col[2];
      out_frame_end_q <= (s1_q.led == lepg_pkg::LED_LAST);
    end
  end

  assign led_o.valid     = out_valid_q;
  assign led_o.led_id    = out_led_q;
  assign led_o.red_out   = out_red_q;
  assign led_o.green_out = out_green_q;
  assign led_o.blue_out  = out_blue_q;
  assign led_o.frame_end = out_frame_end_q;

  // ---------------------------------------------------------------- assertions
  // residues never leave their range
  a_residue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mod40_q < 6'd40) && (mod100_q < 7'd100) && (mod200_q < 8'd200) && (mod800_q < 10'd800))
    else $error("step residue out of range");

  // an emitting tick starts its frame at the first led
  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_inc |=> item_valid_q && (item_led_q == '0))
    else $error("tick did not start a frame");

  // a stalled first stage keeps its led
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_ready |=> s1_valid_q && $stable(s1_q.led))
    else $error("stage 1 lost its led under stall");

  // a value change on the config port restarts the effect
  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_clear |=> (step_q == '0) && (mod800_q == '0))
    else $error("step counter not cleared");

endmodule

### verif/lepg_frame_checker.sv
`timescale 1ns / 100ps
// checker that mirrors the effect registers and step count and compares every led request
module lepg_frame_checker
  import lepg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  lepg_tick_if                  tick_i,
  lepg_led_if                   led_i,
  output int unsigned           leds_outstanding_o,
  output int unsigned           fail_count_o
);

  // led positions around the frame
  localparam int unsigned LED_FRONT = 0;
  localparam int unsigned LED_RIGHT = 1;
  localparam int unsigned LED_BACK  = 2;
  localparam int unsigned LED_LEFT  = 3;

  typedef struct packed {
    logic [LED_IDX_W-1:0] led_id;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
    logic                 frame_end;
  } led_color_t;

  effect_mode_e       mode_q;
  logic [COLOR_W-1:0] base_q [3];
  logic [31:0]        step_q;
  led_color_t         led_color_q [$];
  int unsigned        mismatch_cnt;

  // tilt toward one side, fraction bits dropped, clamped to full scale
  function automatic int unsigned tilt_level(int angle, bit positive_side);
    int unsigned mag;
    if (positive_side) begin
      if (angle <= 0) return 0;
      mag = angle;
    end else begin
      if (angle >= 0) return 0;
      mag = -angle;
    end
    mag = (mag * 5) >> 4;
    return (mag > 255) ? 255 : mag;
  endfunction

  task automatic write_color(int unsigned idx, logic [COLOR_W-1:0] val);
    if (base_q[idx] != val) begin
      base_q[idx] = val;
      step_q = '0;
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  task automatic predict_frame(int roll, int pitch);
    int unsigned col [LED_NUMBER][3];
    int unsigned lvl [LED_NUMBER];
    int unsigned c, s, ph, v, head, tail;
    bit emits;
    led_color_t item;
    emits = 1'b1;
    foreach (col[i, k]) col[i][k] = 0;
    case (mode_q)
      MODE_OFF: emits = (step_q == 0);
      MODE_SOLID: begin
        emits = (step_q == 0);
        foreach (col[i, k]) col[i][k] = base_q[k];
      end
      MODE_SPIN: begin
        head = (step_q / 10) % 4;
        tail = (head + 3) % 4;
        for (int k = 0; k < 3; k++) begin
          col[tail][k] = base_q[k] >> 3;
          col[head][k] = base_q[k];
        end
      end
      MODE_STROBE: begin
        c = step_q % 100;
        if (c == 0 || c == 2 || c == 10 || c == 12) begin
          for (int k = 0; k < 3; k++) begin
            col[LED_FRONT][k] = 255;
            col[LED_BACK][k]  = 255;
            col[LED_RIGHT][k] = base_q[k];
            col[LED_LEFT][k]  = base_q[k];
          end
        end
      end
      MODE_PULSE: begin
        c = step_q % 800;
        s = (c < 400) ? c : 799 - c;
        foreach (col[i, k]) col[i][k] = (base_q[k] * s) / 400;
      end
      MODE_WAVE: begin
        for (int i = 0; i < LED_NUMBER; i++) begin
          ph = ((step_q % 200) + 200 - i * 50) % 200;
          s = (ph < 50) ? ph * 5 : ((ph < 100) ? (99 - ph) * 5 : 0);
          for (int k = 0; k < 3; k++) begin
            v = base_q[k] / 20 + (base_q[k] * s) / 250;
            col[i][k] = (v > 255) ? 255 : v;
          end
        end
      end
      MODE_ATTITUDE: begin
        lvl[LED_LEFT]  = tilt_level(roll, 1'b1);
        lvl[LED_RIGHT] = tilt_level(roll, 1'b0);
        lvl[LED_BACK]  = tilt_level(pitch, 1'b1);
        lvl[LED_FRONT] = tilt_level(pitch, 1'b0);
        for (int i = 0; i < LED_NUMBER; i++) begin
          col[i][0] = (base_q[0] * lvl[i]) / 255;
          col[i][1] = (5 * (255 - lvl[i])) / 255;
          col[i][2] = (base_q[2] * lvl[i]) / 255;
        end
      end
      default: emits = 1'b0;
    endcase
    if (emits) begin
      step_q = step_q + 1;
      for (int i = 0; i < LED_NUMBER; i++) begin
        item.led_id    = LED_IDX_W'(i);
        item.red       = COLOR_W'(col[i][0]);
        item.green     = COLOR_W'(col[i][1]);
        item.blue      = COLOR_W'(col[i][2]);
        item.frame_end = (i == LED_NUMBER - 1);
        led_color_q.push_back(item);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    led_color_t want;
    if (!rst_ni) begin
      mode_q = MODE_OFF;
      foreach (base_q[k]) base_q[k] = '0;
      step_q = '0;
      led_color_q.delete();
      leds_outstanding_o <= 0;
      fail_count_o <= mismatch_cnt;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_MODE: begin
            if (mode_q != effect_mode_e'(cfg_data_i[MODE_W-1:0])) begin
              mode_q = effect_mode_e'(cfg_data_i[MODE_W-1:0]);
              step_q = '0;
            end
          end
          REG_RED:   write_color(0, cfg_data_i);
          REG_GREEN: write_color(1, cfg_data_i);
          REG_BLUE:  write_color(2, cfg_data_i);
          default: ;
        endcase
      end
      if (tick_i.valid && tick_i.ready) predict_frame(tick_i.roll_angle, tick_i.pitch_angle);
      if (led_i.valid && led_i.ready) begin
        if (led_color_q.size() == 0) begin
          $error("led request with no frame pending: led_id %0d", led_i.led_id);
          mismatch_cnt++;
        end else begin
          want = led_color_q.pop_front();
          check_field("led_id", want.led_id, led_i.led_id);
          check_field("red_out", want.red, led_i.red_out);
          check_field("green_out", want.green, led_i.green_out);
          check_field("blue_out", want.blue, led_i.blue_out);
          check_field("frame_end", want.frame_end, led_i.frame_end);
        end
      end
      leds_outstanding_o <= led_color_q.size();
      fail_count_o <= mismatch_cnt;
    end
  end

  initial mismatch_cnt = 0;

endmodule

### verif/led_effect_pattern_generator_tb.sv
`timescale 1ns / 100ps
// testbench top for the led effect pattern generator: clock, reset, tick and register stimulus
module led_effect_pattern_generator_tb;
  import lepg_pkg::*;

  localparam int unsigned RESET_CYCLES  = 7;
  // extra wait after the last predicted led has left, before the next phase
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IDLE_PCT      = 21;
  // tick requests sent over the whole run, directed ones included
  localparam int unsigned TOTAL_TICKS   = 230;
  // watchdog limit on the length of the whole run
  localparam int unsigned CYCLE_LIMIT   = 200000;

  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 2047;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -2048;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int unsigned leds_outstanding;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned ticks_sent;
  bit          quiet_run;     // no gaps on either side while set

  lepg_tick_if tick_if ();
  lepg_led_if  led_if ();

  led_effect_pattern_generator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .tick_i      (tick_if),
    .led_o       (led_if)
  );

  // watches both channels and the register port, predicts and compares
  lepg_frame_checker u_frame_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .tick_i             (tick_if),
    .led_i              (led_if),
    .leds_outstanding_o (leds_outstanding),
    .fail_count_o       (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // led sink: random backpressure, held open during the quiet stretch
  initial begin
    led_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      led_if.ready <= quiet_run || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // mode register byte with random upper bits, which the block must ignore
  function automatic logic [CFG_DATA_W-1:0] mode_byte(effect_mode_e m);
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'($urandom);
    v[MODE_W-1:0] = m;
    return v;
  endfunction

  // color level biased toward the extremes
  function automatic logic [COLOR_W-1:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return '0;
      1, 2:    return '1;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  // angle mix: full range, the region around the clamp point, and the corners
  function automatic logic signed [ANGLE_W-1:0] random_angle();
    case ($urandom_range(0, 3))
      0, 1: return ANGLE_W'($urandom);
      2:    return ANGLE_W'(int'($urandom_range(0, 1800)) - 900);
      default: begin
        case ($urandom_range(0, 4))
          0:       return ANGLE_MIN;
          1:       return ANGLE_MAX;
          2:       return ANGLE_W'(1);
          3:       return ANGLE_W'(-1);
          default: return '0;
        endcase
      end
    endcase
  endfunction

  // one tick request; valid stays high afterwards unless the next call idles first
  task automatic send_tick(logic signed [ANGLE_W-1:0] roll, logic signed [ANGLE_W-1:0] pitch);
    while (!quiet_run && $urandom_range(0, 99) < IDLE_PCT) begin
      tick_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_if.valid       <= 1'b1;
    tick_if.roll_angle  <= roll;
    tick_if.pitch_angle <= pitch;
    @(posedge clk_i);
    while (!tick_if.ready) @(posedge clk_i);
    ticks_sent++;
  endtask

  // writes the registers selected by mask, back to back, then drops the enable
  task automatic write_regs(bit [3:0] mask, logic [CFG_DATA_W-1:0] mode_data,
                            logic [COLOR_W-1:0] red, logic [COLOR_W-1:0] green,
                            logic [COLOR_W-1:0] blue);
    logic [CFG_DATA_W-1:0] vals [4];
    vals[REG_MODE]  = mode_data;
    vals[REG_RED]   = red;
    vals[REG_GREEN] = green;
    vals[REG_BLUE]  = blue;
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        cfg_we_i    <= 1'b1;
        cfg_index_i <= CFG_IDX_W'(i);
        cfg_data_i  <= vals[i];
        @(posedge clk_i);
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  // park the tick channel, let every predicted led leave, then let the pipe settle
  task automatic wait_frames_done();
    tick_if.valid <= 1'b0;
    @(posedge clk_i);
    while (leds_outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    effect_mode_e          cur_mode;
    effect_mode_e          next_mode;
    logic [COLOR_W-1:0]    r, g, b;
    bit [3:0]              mask;
    int unsigned           phase;
    int unsigned           n_ticks;
    int unsigned           emitting_ticks;

    quiet_run = 1'b0;
    ticks_sent = 0;
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_index_i         <= REG_MODE;
    cfg_data_i          <= '0;
    tick_if.valid       <= 1'b0;
    tick_if.roll_angle  <= '0;
    tick_if.pitch_angle <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // off mode straight out of reset: one dark frame, then nothing
    send_tick('0, '0);
    send_tick(ANGLE_MAX, ANGLE_MIN);
    wait_frames_done();

    // solid: a single frame after the step count is cleared
    write_regs(4'b1111, mode_byte(MODE_SOLID), 8'hFF, 8'h00, 8'hFF);
    send_tick('0, '0);
    send_tick('0, '0);
    wait_frames_done();

    // same mode again must not clear the step count, so still no frame
    write_regs(4'b0001, mode_byte(MODE_SOLID), '0, '0, '0);
    send_tick('0, '0);
    wait_frames_done();

    // a changed color clears it and solid lights up once more
    write_regs(4'b0100, '0, '0, 8'h80, '0);
    send_tick('0, '0);
    wait_frames_done();

    // attitude: zero, both corners, smallest tilts, and around the clamp
    write_regs(4'b0001, mode_byte(MODE_ATTITUDE), '0, '0, '0);
    send_tick('0, '0);
    send_tick(ANGLE_MAX, ANGLE_MAX);
    send_tick(ANGLE_MIN, ANGLE_MIN);
    send_tick(ANGLE_W'(1), ANGLE_W'(-1));
    send_tick(ANGLE_W'(-16), ANGLE_W'(16));
    send_tick(ANGLE_W'(52), ANGLE_W'(-52));
    send_tick(ANGLE_W'(816), ANGLE_W'(-817));
    send_tick(ANGLE_W'(-815), ANGLE_W'(820));
    wait_frames_done();

    // mode none: ticks are taken but nothing comes out
    write_regs(4'b0001, mode_byte(MODE_NONE), '0, '0, '0);
    send_tick(ANGLE_MAX, ANGLE_MAX);
    send_tick(ANGLE_MIN, ANGLE_MIN);
    wait_frames_done();

    // strobe: flash, dark, flash
    write_regs(4'b1111, mode_byte(MODE_STROBE), 8'h01, 8'hFE, 8'h7F);
    send_tick('0, '0);
    send_tick('0, '0);
    send_tick('0, '0);
    wait_frames_done();
    cur_mode = MODE_STROBE;

    // random phases; the first few cover the counter-driven modes over long runs,
    // starting with a full-white wave so the saturation at 255 is hit
    phase = 0;
    emitting_ticks = 0;
    while (ticks_sent < TOTAL_TICKS) begin
      case (phase)
        0:       next_mode = MODE_WAVE;
        1:       next_mode = MODE_STROBE;
        2:       next_mode = MODE_SPIN;
        3:       next_mode = MODE_PULSE;
        4:       next_mode = MODE_ATTITUDE;
        default: next_mode = effect_mode_e'(MODE_W'($urandom_range(0, 7)));
      endcase
      r = pick_level();
      g = pick_level();
      b = pick_level();
      if (phase == 0) begin
        r = '1;
        g = '1;
        b = '1;
      end
      // later phases leave some registers alone so the step count runs on
      mask = (phase < 5) ? 4'b1111 : 4'($urandom_range(0, 15));
      write_regs(mask, mode_byte(next_mode), r, g, b);
      if (mask[REG_MODE]) cur_mode = next_mode;

      case (cur_mode)
        MODE_WAVE, MODE_STROBE, MODE_SPIN: n_ticks = $urandom_range(40, 55);
        MODE_OFF, MODE_SOLID, MODE_NONE:   n_ticks = $urandom_range(2, 6);
        default:                           n_ticks = $urandom_range(8, 30);
      endcase
      if (n_ticks > TOTAL_TICKS - ticks_sent) n_ticks = TOTAL_TICKS - ticks_sent;

      for (int i = 0; i < n_ticks; i++) begin
        quiet_run = (emitting_ticks >= 90) && (emitting_ticks < 150);
        send_tick(random_angle(), random_angle());
        if (!(cur_mode inside {MODE_OFF, MODE_SOLID, MODE_NONE})) emitting_ticks++;
      end
      wait_frames_done();
      phase++;
    end
    quiet_run = 1'b0;

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/lepg_pkg.sv
hw/rtl/lepg_if.sv
hw/rtl/led_effect_pattern_generator.sv
verif/lepg_frame_checker.sv
verif/led_effect_pattern_generator_tb.sv
